// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the escape decoder.
// Requires a port or signal named clock and one named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ESU8_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ESU8_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/esu8_pkg.sv =====
// Shared types, codes and constants of the escaped string to UTF-8 decoder.
// No dependencies; used by every other file of the block but assert_macros.svh.
`default_nettype none

package esu8_pkg;

   // default width of the byte and unit counters
   localparam int COUNT_WIDTH_DEF = 16;

   // field widths fixed by the interface
   localparam int UNIT_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int REPORT_W   = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int MAX_BYTES  = 4;

   // register indexes (byte address is 4 times the index)
   localparam logic [1:0] REG_MAX_RESULT_SIZE = 2'd0;
   localparam logic [1:0] REG_LIMIT_ENABLED   = 2'd1;
   localparam logic [1:0] REG_MIN_RESULT_SIZE = 2'd2;
   localparam logic [1:0] REG_COUNT_ONLY      = 2'd3;

   // register reset values
   localparam logic [15:0] MAX_RESULT_SIZE_RST = 16'hFFFF;
   localparam logic        LIMIT_ENABLED_RST   = 1'b0;
   localparam logic [15:0] MIN_RESULT_SIZE_RST = 16'h0000;
   localparam logic        COUNT_ONLY_RST      = 1'b0;

   // result status codes, ordered by severity
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INTER   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_AFTER  = 2'd1,
      MODE_HEX    = 2'd2,
      MODE_OCT    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [15:0] max_result_size;
      logic        limit_enabled;
      logic [15:0] min_result_size;
      logic        count_only;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] escape_value;
      logic [1:0] digits_taken;
      logic [1:0] octal_digit_limit;
      logic [1:0] code_status;
      logic       halted;
      logic       seen_unit;
   } parse_state_type;

   localparam parse_state_type PARSE_RST = '{
      mode:              MODE_NORMAL,
      escape_value:      8'h00,
      digits_taken:      2'd0,
      octal_digit_limit: 2'd3,
      code_status:       ST_OK,
      halted:            1'b0,
      seen_unit:         1'b0
   };

   // what one transaction on the input produces, before counters
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [2:0]                       nbytes;
      logic [1:0]                       status;
      logic                             stop;
   } report_type;

endpackage

`default_nettype wire

// ===== src/esu8_req_if.sv =====
// Input channel of the escape decoder: one UTF-16 code unit per transaction.
// Depends on esu8_pkg.
`default_nettype none

interface esu8_req_if;
   import esu8_pkg::*;

   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] code_unit;
   logic              unit_present;
   logic              end_of_string;

   modport source (output valid, code_unit, unit_present, end_of_string, input ready);
   modport sink   (input valid, code_unit, unit_present, end_of_string, output ready);
endinterface

`default_nettype wire

// ===== src/esu8_rsp_if.sv =====
// Result channel of the escape decoder: one byte or status per transaction.
// Depends on esu8_pkg.
`default_nettype none

interface esu8_rsp_if;
   import esu8_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic                byte_valid;
   logic                run_last;
   logic [1:0]          status;
   logic [REPORT_W-1:0] bytes_so_far;
   logic [REPORT_W-1:0] units_used;
   logic                stopped;

   modport source (output valid, data_byte, byte_valid, run_last, status, bytes_so_far,
                   units_used, stopped, input ready);
   modport sink   (input valid, data_byte, byte_valid, run_last, status, bytes_so_far,
                   units_used, stopped, output ready);
endinterface

`default_nettype wire

// ===== src/esu8_csr.sv =====
// APB-style configuration registers of the escape decoder.
// Depends on esu8_pkg.
`default_nettype none

module esu8_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [esu8_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [esu8_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [esu8_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output esu8_pkg::cfg_type                  cfg
);
   import esu8_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   // write the addressed register at the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_result_size <= MAX_RESULT_SIZE_RST;
         cfg_ff.limit_enabled   <= LIMIT_ENABLED_RST;
         cfg_ff.min_result_size <= MIN_RESULT_SIZE_RST;
         cfg_ff.count_only      <= COUNT_ONLY_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MAX_RESULT_SIZE: cfg_ff.max_result_size <= pwdata[15:0];
            REG_LIMIT_ENABLED:   cfg_ff.limit_enabled   <= pwdata[0];
            REG_MIN_RESULT_SIZE: cfg_ff.min_result_size <= pwdata[15:0];
            REG_COUNT_ONLY:      cfg_ff.count_only      <= pwdata[0];
            default: ;
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_MAX_RESULT_SIZE: prdata = CSR_DATA_W'(cfg_ff.max_result_size);
         REG_LIMIT_ENABLED:   prdata = CSR_DATA_W'(cfg_ff.limit_enabled);
         REG_MIN_RESULT_SIZE: prdata = CSR_DATA_W'(cfg_ff.min_result_size);
         REG_COUNT_ONLY:      prdata = CSR_DATA_W'(cfg_ff.count_only);
         default:             prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/esu8_step.sv =====
// Decode step of the escape decoder: one code unit against the parse state.
// Produces up to four bytes, the status and the next state. Depends on esu8_pkg.
`default_nettype none

module esu8_step #(
   parameter int CountWidth = esu8_pkg::COUNT_WIDTH_DEF
) (
   input  esu8_pkg::cfg_type                 cfg,
   input  esu8_pkg::parse_state_type         pst,
   input  logic [CountWidth-1:0]             bc,
   input  logic [CountWidth-1:0]             uc,
   input  logic [esu8_pkg::UNIT_W-1:0]       code_unit,
   input  logic                              unit_present,
   input  logic                              end_of_string,
   output esu8_pkg::parse_state_type         pst_next,
   output logic [CountWidth-1:0]             bc_next,
   output logic [CountWidth-1:0]             uc_next,
   output logic [CountWidth-1:0]             rep_bc,
   output logic [CountWidth-1:0]             rep_uc,
   output esu8_pkg::report_type              report
);
   import esu8_pkg::*;

   localparam int WideW = (CountWidth > 16) ? CountWidth : 16;
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   logic [WideW-1:0]      max_wide;
   logic [CountWidth-1:0] lim;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (v == CountMax) ? v : v + 1'b1;
   endfunction

   function automatic logic [1:0] worse(input logic [1:0] cur, input logic [1:0] s);
      return (s > cur) ? s : cur;
   endfunction

   // hex digit: valid bit over value
   function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] u);
      logic [4:0] r;
      r = '0;
      if (u >= 16'h0030 && u <= 16'h0039)      r = {1'b1, 4'(u - 16'h0030)};
      else if (u >= 16'h0041 && u <= 16'h0046) r = {1'b1, 4'(u - 16'h0037)};
      else if (u >= 16'h0061 && u <= 16'h0066) r = {1'b1, 4'(u - 16'h0057)};
      return r;
   endfunction

   // octal digit: valid bit over value
   function automatic logic [3:0] oct_digit(input logic [UNIT_W-1:0] u);
      return (u >= 16'h0030 && u <= 16'h0037) ? {1'b1, 3'(u - 16'h0030)} : 4'h0;
   endfunction

   // single-letter control escape: valid bit over byte
   function automatic logic [8:0] ctl_code(input logic [UNIT_W-1:0] u);
      logic [8:0] r;
      unique case (u)
         16'h005C: r = {1'b1, 8'h5C};
         16'h006E: r = {1'b1, 8'h0A};
         16'h0072: r = {1'b1, 8'h0D};
         16'h0074: r = {1'b1, 8'h09};
         16'h0076: r = {1'b1, 8'h0B};
         16'h0066: r = {1'b1, 8'h0C};
         16'h0062: r = {1'b1, 8'h08};
         16'h0061: r = {1'b1, 8'h07};
         default:  r = 9'h000;
      endcase
      return r;
   endfunction

   // effective byte limit
   assign max_wide = WideW'(cfg.max_result_size);
   assign lim = (cfg.limit_enabled && max_wide < WideW'(CountMax))
              ? CountWidth'(max_wide) : CountMax;

   always_comb begin : step_logic
      parse_state_type       s;
      logic [CountWidth-1:0] b;
      logic [CountWidth-1:0] n_units;
      logic [2:0]            nb;
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic                  plain_go;
      logic [4:0]            hx;
      logic [3:0]            oc;
      logic [8:0]            cc;
      logic [1:0]            plen;
      logic [2:0][7:0]       pbytes;
      logic [CountWidth:0]   need;

      s        = pst;
      b        = bc;
      n_units  = uc;
      nb       = '0;
      bytes    = '0;
      plain_go = 1'b0;
      hx       = hex_digit(code_unit);
      oc       = oct_digit(code_unit);
      cc       = ctl_code(code_unit);

      // limit may have been lowered between transactions
      if (!s.halted && b >= lim) s.halted = 1'b1;

      if (unit_present) begin
         s.seen_unit = 1'b1;
         if (!s.halted) begin
            unique case (s.mode)
               MODE_AFTER: begin
                  if (cc[8]) begin
                     if (nb < 3'd4) bytes[nb[1:0]] = cc[7:0];
                     nb = nb + 3'd1;
                     b = sat_inc(b);
                     n_units = sat_inc(n_units);
                     s.mode = MODE_NORMAL;
                  end else if (code_unit == 16'h0078 || code_unit == 16'h0058) begin
                     n_units = sat_inc(n_units);
                     s.escape_value = '0;
                     s.digits_taken = '0;
                     s.mode = MODE_HEX;
                  end else if (oc[3]) begin
                     n_units = sat_inc(n_units);
                     s.escape_value = 8'(oc[2:0]);
                     s.digits_taken = 2'd1;
                     s.octal_digit_limit = (oc[2:0] > 3'd3) ? 2'd2 : 2'd3;
                     s.mode = MODE_OCT;
                  end else begin
                     s.escape_value = '0;
                     plain_go = 1'b1;
                  end
               end
               MODE_HEX: begin
                  if (hx[4]) begin
                     n_units = sat_inc(n_units);
                     s.escape_value = {s.escape_value[3:0], hx[3:0]};
                     s.digits_taken = s.digits_taken + 2'd1;
                     if (s.digits_taken >= 2'd2) begin
                        if (nb < 3'd4) bytes[nb[1:0]] = s.escape_value;
                        nb = nb + 3'd1;
                        b = sat_inc(b);
                        s.mode = MODE_NORMAL;
                     end
                  end else begin
                     plain_go = 1'b1;
                  end
               end
               MODE_OCT: begin
                  if (oc[3]) begin
                     n_units = sat_inc(n_units);
                     s.escape_value = {s.escape_value[4:0], oc[2:0]};
                     s.digits_taken = s.digits_taken + 2'd1;
                     if (s.digits_taken >= s.octal_digit_limit) begin
                        if (nb < 3'd4) bytes[nb[1:0]] = s.escape_value;
                        nb = nb + 3'd1;
                        b = sat_inc(b);
                        s.mode = MODE_NORMAL;
                     end
                  end else begin
                     plain_go = 1'b1;
                  end
               end
               default: ;
            endcase

            // close a short number, then read the unit as plain text
            if (plain_go && s.mode != MODE_NORMAL) begin
               if (nb < 3'd4) bytes[nb[1:0]] = s.escape_value;
               nb = nb + 3'd1;
               b = sat_inc(b);
               s.code_status = worse(s.code_status, ST_INTER);
               s.mode = MODE_NORMAL;
            end
            if (s.mode == MODE_NORMAL && !plain_go && pst.mode == MODE_NORMAL) begin
               plain_go = 1'b1;
            end
         end
      end

      // plain unit: UTF-8 encode with limit check
      plen   = (code_unit < 16'h0080) ? 2'd1 : (code_unit < 16'h0800) ? 2'd2 : 2'd3;
      pbytes = '0;
      unique case (plen)
         2'd1: pbytes[0] = code_unit[7:0];
         2'd2: begin
            pbytes[0] = {3'b110, code_unit[10:6]};
            pbytes[1] = {2'b10, code_unit[5:0]};
         end
         default: begin
            pbytes[0] = {4'b1110, code_unit[15:12]};
            pbytes[1] = {2'b10, code_unit[11:6]};
            pbytes[2] = {2'b10, code_unit[5:0]};
         end
      endcase
      need = {1'b0, b} + (CountWidth + 1)'(plen);

      if (plain_go && !s.halted) begin
         if (b >= lim) begin
            s.halted = 1'b1;
         end else if (code_unit == 16'h005C) begin
            n_units = sat_inc(n_units);
            s.mode = MODE_AFTER;
         end else if (code_unit >= 16'hD800 && code_unit <= 16'hDFFF) begin
            s.code_status = worse(s.code_status, ST_INVALID);
            s.halted = 1'b1;
         end else if (need > {1'b0, lim}) begin
            s.code_status = worse(s.code_status, ST_INVALID);
            s.halted = 1'b1;
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (k < int'(plen)) begin
                  if (nb < 3'd4) bytes[nb[1:0]] = pbytes[k];
                  nb = nb + 3'd1;
                  b = sat_inc(b);
               end
            end
            n_units = sat_inc(n_units);
         end
      end

      // flush a pending escape at the end of the string; flag a string with no unit when a minimum size is set
      if (end_of_string) begin
         if (!s.halted) begin
            if (s.mode == MODE_AFTER) begin
               if (nb < 3'd4) bytes[nb[1:0]] = 8'h00;
               nb = nb + 3'd1;
               b = sat_inc(b);
               s.code_status = worse(s.code_status, ST_INTER);
            end else if (s.mode == MODE_HEX || s.mode == MODE_OCT) begin
               if (nb < 3'd4) bytes[nb[1:0]] = s.escape_value;
               nb = nb + 3'd1;
               b = sat_inc(b);
               s.code_status = worse(s.code_status, ST_INTER);
            end
            s.mode = MODE_NORMAL;
         end
         if (!s.seen_unit && cfg.min_result_size != '0) begin
            s.code_status = worse(s.code_status, ST_INTER);
         end
      end

      report.bytes  = bytes;
      report.nbytes = nb;
      report.status = s.code_status;
      report.stop   = s.halted || (b >= lim);
      rep_bc        = b;
      rep_uc        = n_units;

      // start over after the end of a string
      pst_next = end_of_string ? PARSE_RST : s;
      bc_next  = end_of_string ? '0 : b;
      uc_next  = end_of_string ? '0 : n_units;
   end

endmodule

`default_nettype wire

// ===== src/escaped_string_to_utf8_bytes.sv =====
// Top level of the C-style escaped string to UTF-8 byte decoder.
// Depends on esu8_pkg, esu8_req_if, esu8_rsp_if, esu8_csr, esu8_step, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Decodes one UTF-16 code unit per input transaction of an escaped string and
// emits the resulting bytes, one byte per result transaction, each carrying the
// running status, byte count, consumed unit count and stop flag; an item with no
// byte (or any item in count-only mode) gives one status-only result. Each item
// is decoded in the cycle it is accepted and its results appear from the next
// cycle out of a four-byte result buffer, which holds an item's results until
// the sink takes them, so the block takes one item per cycle while items give
// one result each and the sink is ready; an item with several bytes holds the
// input until its last result is taken. A string ends with an end_of_string item,
// after which all decode state returns to its reset value. Configure through
// the APB port only while no transaction is in flight.
module escaped_string_to_utf8_bytes #(
   parameter int CountWidth = esu8_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   esu8_req_if.sink                           req_ch,
   esu8_rsp_if.source                         rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [esu8_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [esu8_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [esu8_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import esu8_pkg::*;

   cfg_type               cfg;
   parse_state_type       pst_ff, pst_in;
   logic [CountWidth-1:0] bc_ff, bc_in;
   logic [CountWidth-1:0] uc_ff, uc_in;
   logic [CountWidth-1:0] rep_bc, rep_uc;
   report_type            report;

   logic [MAX_BYTES-1:0][BYTE_W-1:0] obuf_ff;
   logic [2:0]                       rem_ff;
   logic                             obyte_ff;
   logic [1:0]                       ostatus_ff;
   logic [REPORT_W-1:0]              obc_ff;
   logic [REPORT_W-1:0]              ouc_ff;
   logic                             ostop_ff;

   logic accept;
   logic take;
   logic emit_bytes;

   esu8_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   esu8_step #(.CountWidth(CountWidth)) u_step (
      .cfg           (cfg),
      .pst           (pst_ff),
      .bc            (bc_ff),
      .uc            (uc_ff),
      .code_unit     (req_ch.code_unit),
      .unit_present  (req_ch.unit_present),
      .end_of_string (req_ch.end_of_string),
      .pst_next      (pst_in),
      .bc_next       (bc_in),
      .uc_next       (uc_in),
      .rep_bc        (rep_bc),
      .rep_uc        (rep_uc),
      .report        (report)
   );

   // take a new item when the buffer is empty or gives up its last result now
   assign req_ch.ready = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign take         = rsp_ch.valid && rsp_ch.ready;
   assign emit_bytes   = !cfg.count_only && report.nbytes != 3'd0;

   // hold decode state between items
   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff <= PARSE_RST;
         bc_ff  <= '0;
         uc_ff  <= '0;
      end else if (accept) begin
         pst_ff <= pst_in;
         bc_ff  <= bc_in;
         uc_ff  <= uc_in;
      end
   end

   // result buffer: load on accept, advance one byte per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (accept) begin
         rem_ff <= emit_bytes ? report.nbytes : 3'd1;
      end else if (take) begin
         rem_ff <= rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         obuf_ff    <= emit_bytes ? report.bytes : '0;
         obyte_ff   <= emit_bytes;
         ostatus_ff <= report.status;
         obc_ff     <= REPORT_W'(rep_bc);
         ouc_ff     <= REPORT_W'(rep_uc);
         ostop_ff   <= report.stop;
      end else if (take) begin
         obuf_ff <= obuf_ff >> BYTE_W;
      end
   end

   assign rsp_ch.valid        = rem_ff != 3'd0;
   assign rsp_ch.data_byte    = obuf_ff[0];
   assign rsp_ch.byte_valid   = obyte_ff;
   assign rsp_ch.run_last     = rem_ff == 3'd1;
   assign rsp_ch.status       = ostatus_ff;
   assign rsp_ch.bytes_so_far = obc_ff;
   assign rsp_ch.units_used   = ouc_ff;
   assign rsp_ch.stopped      = ostop_ff;

   `ESU8_ASSERT_NOW(a_buf_depth, 1'b1, rem_ff <= 3'd4, "result buffer count out of range")
   `ESU8_ASSERT_NOW(a_status_alone, rsp_ch.valid && !rsp_ch.byte_valid, rsp_ch.run_last,
      "status-only result is not the last of its item")
   `ESU8_ASSERT_NOW(a_no_bytes_counting, rsp_ch.valid && rsp_ch.byte_valid, !cfg.count_only,
      "byte result emitted in count-only mode")
   `ESU8_ASSERT_NEXT(a_string_reset, accept && req_ch.end_of_string,
      bc_ff == '0 && uc_ff == '0 && pst_ff.mode == MODE_NORMAL && !pst_ff.halted,
      "decode state not cleared after end of string")

endmodule

`default_nettype wire
